// ===== src/aphrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphrt_pkg
// Shared types and constants of the all-pairs hop route table.
// ----------------------------------------------------------------------------
package aphrt_pkg;

  // fixed field widths of the stream items
  localparam int ID_W      = 4;
  localparam int ROW_W     = 16;
  localparam int HOP_W     = 4;
  localparam int NODES_DEF = 16;

  // item kinds carried in tuser
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // one route table entry as stored and as delivered
  typedef struct packed {
    logic             reach;
    logic [HOP_W-1:0] hops;
    logic [ID_W-1:0]  first;
  } entry_t;

endpackage

// ===== src/aphrt_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aphrt_search
// Rebuilds the route tables: a unit-weight shortest path search from every
// source, one node a cycle through a rotating node line and one compare unit.
// ----------------------------------------------------------------------------
module aphrt_search #(
  parameter int NODES = aphrt_pkg::NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           done_o,
  output logic [$clog2(NODES)-1:0]       row_idx_o,
  input  logic [aphrt_pkg::ROW_W-1:0]    row_i,
  output logic                           wr_en_o,
  output logic [2*$clog2(NODES)-1:0]     wr_addr_o,
  output aphrt_pkg::entry_t              wr_data_o
);
  import aphrt_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int DW = NW;
  localparam logic [NW-1:0] LAST = NW'(NODES - 1);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_SCAN} state_e;

  state_e            state_q;
  logic [NW-1:0]     s_q, n_q, k_q, kfirst_q, best_idx_q, best_first_q;
  logic [DW-1:0]     kdist_q, best_d_q;
  logic              relax_q, found_q, done_q;
  logic [DW-1:0]     dist_q  [NODES];
  logic [NW-1:0]     first_q [NODES];
  logic [NODES-1:0]  vis_q, reach_q;

  logic [NODES-1:0]  row_ext;
  logic [DW:0]       kd1;
  logic              link_n, relax, cand;
  logic [DW-1:0]     hd;
  logic [NW-1:0]     hf;
  logic              hr, hvis;
  logic [DW+3:0]     hd_w;
  logic [NW+3:0]     hf_w;

  // adjacency row widened to the node count, missing bits read as no link
  for (genvar g = 0; g < NODES; g++) begin : g_row
    if (g < ROW_W) begin : g_in
      assign row_ext[g] = row_i[g];
    end else begin : g_out
      assign row_ext[g] = 1'b0;
    end
  end

  assign row_idx_o = (state_q == S_INIT) ? s_q : k_q;

  // relax and select on the node at the head of the line
  always_comb begin
    kd1    = {1'b0, kdist_q} + (DW+1)'(1);
    link_n = row_ext[n_q];
    relax  = relax_q && (n_q != k_q) && link_n &&
             (!reach_q[0] || ({1'b0, dist_q[0]} > kd1));
    hd     = relax ? kd1[DW-1:0] : dist_q[0];
    hf     = relax ? kfirst_q : first_q[0];
    hr     = reach_q[0] | relax;
    hvis   = vis_q[0] | (relax_q && (n_q == k_q));
    cand   = !hvis && hr && (!found_q || (hd < best_d_q));
    hd_w   = (DW+4)'(hd);
    hf_w   = (NW+4)'(hf);
  end

  // table write of the head entry, the last pass leaves the final values
  assign wr_en_o   = (state_q == S_SCAN);
  assign wr_addr_o = {s_q, n_q};
  always_comb begin
    wr_data_o.reach = hr;
    wr_data_o.hops  = '0;
    wr_data_o.first = '0;
    if (hr) begin
      wr_data_o.hops  = (hd_w > (DW+4)'(15)) ? HOP_W'(15) : hd_w[HOP_W-1:0];
      wr_data_o.first = hf_w[ID_W-1:0];
    end
  end

  assign done_o = done_q;

  // sequencer and rotating node line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_q     <= '0;
      n_q     <= '0;
      relax_q <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // done pulse lasts the first idle cycle only
          done_q <= 1'b0;
          if (start_i) begin
            s_q     <= '0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          for (int i = 0; i < NODES; i++) begin
            if (NW'(i) == s_q) begin
              vis_q[i]   <= 1'b1;
              reach_q[i] <= 1'b1;
              dist_q[i]  <= '0;
              first_q[i] <= s_q;
            end else begin
              vis_q[i]   <= 1'b0;
              reach_q[i] <= row_ext[i];
              dist_q[i]  <= DW'(1);
              first_q[i] <= row_ext[i] ? NW'(i) : '0;
            end
          end
          n_q     <= '0;
          relax_q <= 1'b0;
          found_q <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          for (int i = 0; i < NODES - 1; i++) begin
            dist_q[i]  <= dist_q[i+1];
            first_q[i] <= first_q[i+1];
            vis_q[i]   <= vis_q[i+1];
            reach_q[i] <= reach_q[i+1];
          end
          dist_q[NODES-1]  <= hd;
          first_q[NODES-1] <= hf;
          vis_q[NODES-1]   <= hvis;
          reach_q[NODES-1] <= hr;
          if (n_q != LAST) begin
            n_q <= n_q + NW'(1);
            if (cand) begin
              found_q      <= 1'b1;
              best_d_q     <= hd;
              best_idx_q   <= n_q;
              best_first_q <= hf;
            end
          end else begin
            n_q     <= '0;
            found_q <= 1'b0;
            if (found_q || cand) begin
              // next node to settle
              relax_q  <= 1'b1;
              k_q      <= cand ? n_q : best_idx_q;
              kdist_q  <= cand ? hd : best_d_q;
              kfirst_q <= cand ? hf : best_first_q;
            end else if (s_q == LAST) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              s_q     <= s_q + NW'(1);
              state_q <= S_INIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/all_pairs_hop_route_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_hop_route_table_top
// Adjacency row store and route lookup with rebuild of the route tables.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one adjacency row and marks the route tables
// stale. A lookup item (tuser 1) on fresh tables passes through the T_READ
// state, the registered table read and the T_RESP state into the output
// register. A lookup on stale tables first rebuilds them: for each source, an
// initialization step and then passes over all NODES nodes, one node a cycle
// through the shared relax and select unit, with one pass for each node the
// source reaches plus one. The input is not ready during a lookup or a
// rebuild; the result sits in an output register, so further writes are
// taken meanwhile.
// ----------------------------------------------------------------------------
module all_pairs_hop_route_table_top #(
  parameter int NODES = aphrt_pkg::NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // src[3:0], dst[7:4], row_bits[23:8]
  input  logic        s_axis_tuser,  // kind[0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // next_hop[3:0], hops[7:4], reachable[8], zeros
);
  import aphrt_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int ROWS  = (NODES < ROW_W) ? NODES : ROW_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TBL_D = 2 ** (2 * NW);

  typedef enum logic [1:0] {T_IDLE, T_BUILD, T_READ, T_RESP} state_e;

  state_e             state_q;
  logic [ROW_W-1:0]   adj_q [ROWS];
  logic               stale_q;
  entry_t             tbl_q [TBL_D];
  entry_t             rd_q, out_q;
  logic [2*NW-1:0]    rd_addr_q;
  logic               oob_q, out_valid_q;

  logic [ID_W-1:0]    in_src, in_dst;
  logic [ROW_W-1:0]   in_row;
  logic               in_acc, eng_start, eng_done, eng_wr_en;
  logic [NW-1:0]      eng_row_idx;
  logic [ROW_W-1:0]   eng_row;
  logic [2*NW-1:0]    eng_wr_addr;
  entry_t             eng_wr_data;

  assign in_src = s_axis_tdata[3:0];
  assign in_dst = s_axis_tdata[7:4];
  assign in_row = s_axis_tdata[23:8];

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign eng_start     = in_acc && (s_axis_tuser == KIND_LOOKUP) && stale_q;

  // adjacency row for the search engine
  assign eng_row = (32'(eng_row_idx) < ROWS) ? adj_q[eng_row_idx[RW-1:0]] : '0;

  aphrt_search #(
    .NODES (NODES)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .done_o    (eng_done),
    .row_idx_o (eng_row_idx),
    .row_i     (eng_row),
    .wr_en_o   (eng_wr_en),
    .wr_addr_o (eng_wr_addr),
    .wr_data_o (eng_wr_data)
  );

  // route table memory
  always_ff @(posedge clk_i) begin
    if (eng_wr_en) begin
      tbl_q[eng_wr_addr] <= eng_wr_data;
    end
    rd_q <= tbl_q[rd_addr_q];
  end

  // lookup address capture
  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == KIND_LOOKUP)) begin
      rd_addr_q <= {NW'(in_src), NW'(in_dst)};
      oob_q     <= (32'(in_src) >= NODES) || (32'(in_dst) >= NODES);
    end
  end

  // control, adjacency rows and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      stale_q     <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        adj_q[i] <= '0;
      end
    end else begin
      // output drains here unless a new result is loaded below
      if (out_valid_q && m_axis_tready && (state_q != T_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == KIND_WRITE) begin
              if (32'(in_src) < ROWS) begin
                adj_q[in_src[RW-1:0]] <= in_row;
                stale_q               <= 1'b1;
              end
            end else begin
              state_q <= stale_q ? T_BUILD : T_READ;
            end
          end
        end
        T_BUILD: begin
          if (eng_done) begin
            stale_q <= 1'b0;
            state_q <= T_READ;
          end
        end
        T_READ: begin
          state_q <= T_RESP;
        end
        T_RESP: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= oob_q ? '0 : rd_q;
            out_valid_q <= 1'b1;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.reach, out_q.hops, out_q.first};

endmodule

// ===== tb/all_pairs_hop_route_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_hop_route_table_top_tb
// Self-checking bench for the all-pairs hop route table.
// ----------------------------------------------------------------------------
// Writes adjacency rows and looks up routes through the input stream. A local
// shortest-path search over its own copy of the adjacency rows predicts each
// lookup result, and every result taken from the output stream is checked
// field by field against the oldest prediction. Directed cases cover the empty
// graph, self-links, tie-breaks and a long output stall; random graphs of
// several shapes, from empty to dense and long chains, follow. Both streams
// idle at random.
// ----------------------------------------------------------------------------
module all_pairs_hop_route_table_top_tb;
  import aphrt_pkg::*;

  localparam int          NODE_COUNT  = NODES_DEF;
  localparam int unsigned DIST_NONE   = 32'hFFFF;
  localparam int          ITEM_TARGET = 1150;
  localparam int          LONG_HOLD   = 300;
  localparam int          STALL_LIMIT = 20000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int          MAX_REPORTS = 10;

  // graph shapes for the random part
  typedef enum int {
    SHAPE_EMPTY,
    SHAPE_SPARSE,
    SHAPE_DENSE,
    SHAPE_CHAIN,
    SHAPE_RING
  } shape_e;
  localparam int NUM_SHAPES = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // src[3:0], dst[7:4], row_bits[23:8]
  logic        s_axis_tuser = 1'b0;  // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // next_hop[3:0], hops[7:4], reachable[8], zeros

  // adjacency copy, route tables and the routes still owed by the block
  logic [15:0] adj_rows [NODE_COUNT];
  entry_t      route_tbl [NODE_COUNT][NODE_COUNT];
  logic        routes_stale;
  entry_t      pending_routes [$];

  int          error_count = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  all_pairs_hop_route_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // unit-weight search from every source, lowest index wins a tie
  function automatic void rebuild_routes();
    int unsigned hop_dist [NODE_COUNT];
    logic [3:0]  first [NODE_COUNT];
    bit          done [NODE_COUNT];
    int unsigned best;
    int          k;
    bit          found;
    for (int s = 0; s < NODE_COUNT; s++) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        done[n] = 1'b0;
        if (n == s) begin
          hop_dist[n] = 0;
          first[n]    = 4'(s);
        end else if (adj_rows[s][n]) begin
          hop_dist[n] = 1;
          first[n]    = 4'(n);
        end else begin
          hop_dist[n] = DIST_NONE;
          first[n]    = '0;
        end
      end
      done[s] = 1'b1;
      for (int round = 0; round < NODE_COUNT; round++) begin
        best  = DIST_NONE;
        k     = 0;
        found = 1'b0;
        for (int n = 0; n < NODE_COUNT; n++) begin
          if (!done[n] && hop_dist[n] < best) begin
            best  = hop_dist[n];
            k     = n;
            found = 1'b1;
          end
        end
        // nothing left at a finite distance
        if (!found) break;
        done[k] = 1'b1;
        for (int n = 0; n < NODE_COUNT; n++) begin
          if (n != k && adj_rows[k][n] && hop_dist[n] > hop_dist[k] + 1) begin
            hop_dist[n] = hop_dist[k] + 1;
            first[n]    = first[k];
          end
        end
      end
      for (int n = 0; n < NODE_COUNT; n++) begin
        if (hop_dist[n] == DIST_NONE) begin
          route_tbl[s][n] = '0;
        end else begin
          route_tbl[s][n].reach = 1'b1;
          route_tbl[s][n].hops  = (hop_dist[n] > 15) ? 4'd15 : 4'(hop_dist[n]);
          route_tbl[s][n].first = first[n];
        end
      end
    end
    routes_stale = 1'b0;
  endfunction

  // track one accepted item: store a row or owe a route
  function automatic void predict_item(input logic kind, input logic [3:0] src,
                                       input logic [3:0] dst, input logic [15:0] row);
    if (kind == KIND_WRITE) begin
      adj_rows[src] = row;
      routes_stale  = 1'b1;
    end else begin
      if (routes_stale) rebuild_routes();
      pending_routes = {pending_routes, route_tbl[src][dst]};
    end
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] error: %s", $time, what);
  endtask

  // offer one item and wait for the block to take it
  task automatic send_item(input logic kind, input logic [3:0] src,
                           input logic [3:0] dst, input logic [15:0] row);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, dst, src};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, src, dst, row);
    items_sent++;
  endtask

  // dst is a don't-care on a write, row_bits on a lookup
  task automatic write_row(input logic [3:0] src, input logic [15:0] row);
    send_item(KIND_WRITE, src, 4'($urandom), row);
  endtask

  task automatic lookup_route(input logic [3:0] src, input logic [3:0] dst);
    send_item(KIND_LOOKUP, src, dst, 16'($urandom));
  endtask

  function automatic logic [15:0] random_row(input shape_e shape);
    logic [15:0] row;
    row = '0;
    case (shape)
      SHAPE_EMPTY: row = '0;
      SHAPE_SPARSE: begin
        for (int n = 0; n < NODE_COUNT; n++) row[n] = ($urandom_range(0, 7) == 0);
      end
      SHAPE_DENSE: row = 16'($urandom);
      default: row = 16'h0001 << $urandom_range(0, 15);
    endcase
    return row;
  endfunction

  // rewrite every row; chains and rings run through a shuffled node order
  task automatic write_graph(input shape_e shape);
    logic [3:0]  order [NODE_COUNT];
    logic [15:0] rows [NODE_COUNT];
    logic [3:0]  swap;
    int          j;
    for (int n = 0; n < NODE_COUNT; n++) begin
      order[n] = 4'(n);
      rows[n]  = random_row(shape);
    end
    if (shape == SHAPE_CHAIN || shape == SHAPE_RING) begin
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        swap     = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
      for (int n = 0; n < NODE_COUNT; n++) rows[n] = '0;
      for (int i = 0; i < NODE_COUNT - 1; i++) rows[order[i]][order[i+1]] = 1'b1;
      if (shape == SHAPE_RING) rows[order[NODE_COUNT-1]][order[0]] = 1'b1;
    end
    for (int n = 0; n < NODE_COUNT; n++) write_row(4'(n), rows[n]);
  endtask

  // lookups before any link exists, first one forces a rebuild
  task automatic test_empty_graph();
    lookup_route(4'd0, 4'd0);
    lookup_route(4'd3, 4'd9);
    lookup_route(4'd15, 4'd15);
  endtask

  // self-links are ignored, a full row reaches every other node in one hop
  task automatic test_self_links();
    write_row(4'd5, 16'h0020);
    lookup_route(4'd5, 4'd5);
    lookup_route(4'd5, 4'd0);
    write_row(4'd0, 16'hFFFF);
    lookup_route(4'd0, 4'd0);
    lookup_route(4'd0, 4'd15);
    write_row(4'd15, 16'h0001);
    lookup_route(4'd15, 4'd3);
    lookup_route(4'd15, 4'd15);
  endtask

  // two equal paths, the lower first hop must win; dead-end node
  task automatic test_tie_break();
    write_row(4'd1, 16'h000C);
    write_row(4'd2, 16'h0010);
    write_row(4'd3, 16'h0010);
    lookup_route(4'd1, 4'd4);
    lookup_route(4'd4, 4'd1);
  endtask

  // receiver holds off while lookups keep coming, block must stall its input
  task automatic test_long_hold();
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    write_row(4'd7, 16'h0100);
    lookup_route(4'd7, 4'd8);
    write_row(4'd8, 16'h0002);
    lookup_route(4'd8, 4'd4);
    lookup_route(4'd7, 4'd4);
    lookup_route(4'd9, 4'd9);
    tx_gaps_on = 1'b1;
  endtask

  // a few row writes or a whole new graph, then a run of lookups
  task automatic test_random_graphs();
    shape_e      shape;
    int unsigned n_writes;
    int unsigned n_looks;
    while (items_sent < ITEM_TARGET) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      shape      = shape_e'($urandom_range(0, NUM_SHAPES - 1));
      if ($urandom_range(0, 3) == 0) begin
        write_graph(shape);
      end else begin
        n_writes = $urandom_range(1, 3);
        repeat (n_writes) write_row(4'($urandom_range(0, 15)), random_row(shape));
      end
      n_looks = $urandom_range(6, 20);
      repeat (n_looks) lookup_route(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  // main sequence
  initial begin
    for (int n = 0; n < NODE_COUNT; n++) adj_rows[n] = '0;
    routes_stale = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_graph();
    test_self_links();
    test_tie_break();
    test_long_hold();
    test_random_graphs();
    s_axis_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // output ready: random gaps per item, one long hold on request
  initial begin : drive_ready
    int unsigned wait_left;
    wait_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        wait_left = LONG_HOLD;
      end else if (m_axis_tvalid && m_axis_tready) begin
        if ($urandom_range(0, 39) == 0) rx_gaps_on = ~rx_gaps_on;
        wait_left = rx_gaps_on ? $urandom_range(0, 5) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      m_axis_tready <= (wait_left == 0);
    end
  end

  // compare each taken result with the oldest owed route
  always @(posedge clk_i) begin : check_results
    entry_t want;
    entry_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.first = m_axis_tdata[3:0];
      got.hops  = m_axis_tdata[7:4];
      got.reach = m_axis_tdata[8];
      if (pending_routes.size() == 0) begin
        flag_error($sformatf("unexpected result next_hop %0d hops %0d reachable %0b",
                             got.first, got.hops, got.reach));
      end else begin
        want = pending_routes.pop_front();
        if (got.first !== want.first || got.hops !== want.hops ||
            got.reach !== want.reach) begin
          flag_error($sformatf({"expected next_hop %0d hops %0d reachable %0b, ",
                                "got next_hop %0d hops %0d reachable %0b"},
                               want.first, want.hops, want.reach,
                               got.first, got.hops, got.reach));
        end
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
